// ===== src/gdad_pkg.sv =====
// gdad_pkg: shared types, constants and calendar helpers for the date adder
// used by gdad_ctrl, gdad_datapath and gregorian_date_add_days_core
`default_nettype none

package gdad_pkg;

   localparam int unsigned DAY_W    = 5;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned YEAR_W   = 14;
   localparam int unsigned OFS_W    = 17;
   localparam int unsigned STAT_W   = 2;
   // working year has one extra bit: stepping forward from the top of the
   // input range runs past 14 bits
   localparam int unsigned WYEAR_W  = YEAR_W + 1;
   localparam int unsigned CNT_W    = 16;
   localparam int unsigned REM_W    = 9;

   localparam logic [OFS_W-1:0]   MAX_DAYS   = 17'd65535;
   localparam logic [WYEAR_W-1:0] FIRST_YEAR = 15'd1582;
   localparam logic [WYEAR_W-1:0] LAST_YEAR  = 15'd9999;
   localparam logic [YEAR_W-1:0]  LEAP_CYCLE = 14'd400;
   localparam logic [REM_W-1:0]   CYCLE_LAST = 9'd399;

   localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_DATE  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_YEAR_OOR  = 2'd2;

   typedef struct packed {
      logic load;
      logic reduce;
      logic check;
      logic step;
      logic publish;
   } gdad_cmd_type;

   typedef struct packed {
      logic red_done;
      logic bad_date;
      logic walk_done;
   } gdad_sts_type;

   // leap test on the year modulo 400
   function automatic logic leap_of(input logic [REM_W-1:0] r);
      return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      len = 5'd31;
      if (m == MON_FEB) begin
         len = leap ? 5'd29 : 5'd28;
      end else if ((m == MON_APR) || (m == MON_JUN) || (m == MON_SEP) || (m == MON_NOV)) begin
         len = 5'd30;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== src/gdad_datapath.sv =====
// gdad_datapath: date registers, remaining day count, year-mod-400 tracker
// and result registers; driven by gdad_ctrl commands, uses gdad_pkg
`default_nettype none

module gdad_datapath (
   input  wire logic                          clock,
   input  wire logic [gdad_pkg::DAY_W-1:0]    req_in_day,
   input  wire logic [gdad_pkg::MONTH_W-1:0]  req_in_month,
   input  wire logic [gdad_pkg::YEAR_W-1:0]   req_in_year,
   input  wire logic signed [gdad_pkg::OFS_W-1:0] req_day_offset,
   input  wire gdad_pkg::gdad_cmd_type        cmd,
   output gdad_pkg::gdad_sts_type             sts,
   output logic [gdad_pkg::DAY_W-1:0]         rsp_out_day,
   output logic [gdad_pkg::MONTH_W-1:0]       rsp_out_month,
   output logic [gdad_pkg::YEAR_W-1:0]        rsp_out_year,
   output logic [gdad_pkg::STAT_W-1:0]        rsp_status
);
   import gdad_pkg::*;

   logic [DAY_W-1:0]   day_ff,   day_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [WYEAR_W-1:0] year_ff,  year_in;
   logic [CNT_W-1:0]   cnt_ff,   cnt_in;
   logic               back_ff,  back_in;
   logic [YEAR_W-1:0]  rem_ff,   rem_in;
   logic               bad_ff,   bad_in;

   logic [DAY_W-1:0]   od_ff,  od_in;
   logic [MONTH_W-1:0] om_ff,  om_in;
   logic [YEAR_W-1:0]  oy_ff,  oy_in;
   logic [STAT_W-1:0]  ost_ff, ost_in;

   logic [OFS_W-1:0]   raw;
   logic [OFS_W-1:0]   mag;
   logic [REM_W-1:0]   rem9;
   logic               leap;
   logic [DAY_W-1:0]   len;
   logic [DAY_W-1:0]   rest;
   logic [MONTH_W-1:0] prev_month;

   always_comb begin
      raw        = req_day_offset;
      mag        = raw[OFS_W-1] ? (17'd0 - raw) : raw;
      rem9       = rem_ff[REM_W-1:0];
      leap       = leap_of(rem9);
      len        = month_len(month_ff, leap);
      rest       = len - day_ff;
      prev_month = month_ff - 4'd1;

      sts.red_done  = (rem_ff < LEAP_CYCLE);
      sts.bad_date  = (year_ff < FIRST_YEAR) || (month_ff == 4'd0) || (month_ff > MON_DEC) ||
                      (day_ff == 5'd0) || (day_ff > len);
      sts.walk_done = (cnt_ff == 16'd0);

      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      cnt_in   = cnt_ff;
      back_in  = back_ff;
      rem_in   = rem_ff;
      bad_in   = bad_ff;
      od_in    = od_ff;
      om_in    = om_ff;
      oy_in    = oy_ff;
      ost_in   = ost_ff;

      if (cmd.load) begin
         day_in   = req_in_day;
         month_in = req_in_month;
         year_in  = {1'b0, req_in_year};
         rem_in   = req_in_year;
         back_in  = raw[OFS_W-1];
         cnt_in   = (mag > MAX_DAYS) ? MAX_DAYS[CNT_W-1:0] : mag[CNT_W-1:0];
      end

      if (cmd.reduce && !sts.red_done) begin
         rem_in = rem_ff - LEAP_CYCLE;
      end

      if (cmd.check) begin
         bad_in = sts.bad_date;
      end

      // one month boundary per cycle
      if (cmd.step) begin
         if (!back_ff) begin
            if (cnt_ff <= {11'd0, rest}) begin
               day_in = day_ff + cnt_ff[DAY_W-1:0];
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff - {11'd0, rest} - 16'd1;
               day_in = 5'd1;
               if (month_ff == MON_DEC) begin
                  month_in = MON_JAN;
                  year_in  = year_ff + 15'd1;
                  rem_in   = (rem9 == CYCLE_LAST) ? '0 : {5'd0, rem9 + 9'd1};
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end
         end else begin
            if (cnt_ff < {11'd0, day_ff}) begin
               day_in = day_ff - cnt_ff[DAY_W-1:0];
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff - {11'd0, day_ff};
               if (month_ff == MON_JAN) begin
                  month_in = MON_DEC;
                  year_in  = year_ff - 15'd1;
                  rem_in   = (rem9 == 9'd0) ? {5'd0, CYCLE_LAST} : {5'd0, rem9 - 9'd1};
                  day_in   = 5'd31;
               end else begin
                  month_in = prev_month;
                  day_in   = month_len(prev_month, leap);
               end
            end
         end
      end

      if (cmd.publish) begin
         od_in = day_ff;
         om_in = month_ff;
         oy_in = year_ff[YEAR_W-1:0];
         if (bad_ff) begin
            ost_in = STAT_BAD_DATE;
         end else if ((year_ff < FIRST_YEAR) || (year_ff > LAST_YEAR)) begin
            ost_in = STAT_YEAR_OOR;
         end else begin
            ost_in = STAT_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      cnt_ff   <= cnt_in;
      back_ff  <= back_in;
      rem_ff   <= rem_in;
      bad_ff   <= bad_in;
      od_ff    <= od_in;
      om_ff    <= om_in;
      oy_ff    <= oy_in;
      ost_ff   <= ost_in;
   end

   assign rsp_out_day   = od_ff;
   assign rsp_out_month = om_ff;
   assign rsp_out_year  = oy_ff;
   assign rsp_status    = ost_ff;

endmodule

`default_nettype wire

// ===== src/gdad_ctrl.sv =====
// gdad_ctrl: sequencer for the date adder (load, mod-400 reduce, check,
// month walk, publish) and the result valid flag; uses gdad_pkg
`default_nettype none

module gdad_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire gdad_pkg::gdad_sts_type  sts,
   output gdad_pkg::gdad_cmd_type       cmd
);
   import gdad_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_STEP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      req_ready   = (state_ff == ST_IDLE);
      cmd.load    = req_ready && req_valid;
      cmd.reduce  = (state_ff == ST_REDUCE);
      cmd.check   = (state_ff == ST_CHECK);
      cmd.step    = (state_ff == ST_STEP) && !sts.walk_done;
      cmd.publish = (state_ff == ST_FINISH) && out_free;

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (sts.red_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sts.bad_date ? ST_FINISH : ST_STEP;
         end
         ST_STEP: begin
            if (sts.walk_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.reduce, cmd.check, cmd.step, cmd.publish}))
      else $error("more than one datapath command at once");

   a_load_reduce: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_REDUCE))
      else $error("accepted beat did not start the mod-400 reduction");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not flagged valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.publish)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== src/gregorian_date_add_days_core.sv =====
// gregorian_date_add_days_core: top level of the Gregorian date adder
// joins gdad_ctrl and gdad_datapath; uses gdad_pkg
//
//  - request beat (req_valid/req_ready): start date req_in_day, req_in_month,
//    req_in_year and a signed day count req_day_offset; the count magnitude
//    is clamped to 65535 days with its sign kept
//  - response beat (rsp_valid/rsp_ready): result date and rsp_status
//    (0 ok, 1 bad start date echoed back, 2 result year outside 1582..9999)
//  - one request at a time; req_ready is high only while the sequencer idles
//  - each request runs through accept, reduction of the year modulo 400 (one
//    subtract of 400 per cycle until the remainder is below 400), check, the
//    month walk (one month boundary per cycle, then the last partial month)
//    and the load of the result register; rsp_valid rises the cycle after,
//    and the next request can be taken then; a bad date skips the month walk
//  - the result register decouples the sides: once a result is loaded the
//    core returns to idle and takes the next request even while rsp_ready
//    is low; a second result waits until the first beat is taken
//  - synchronous reset returns the sequencer to idle and drops rsp_valid
`default_nettype none

module gregorian_date_add_days_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [gdad_pkg::DAY_W-1:0]        req_in_day,
   input  wire logic [gdad_pkg::MONTH_W-1:0]      req_in_month,
   input  wire logic [gdad_pkg::YEAR_W-1:0]       req_in_year,
   input  wire logic signed [gdad_pkg::OFS_W-1:0] req_day_offset,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [gdad_pkg::DAY_W-1:0]             rsp_out_day,
   output logic [gdad_pkg::MONTH_W-1:0]           rsp_out_month,
   output logic [gdad_pkg::YEAR_W-1:0]            rsp_out_year,
   output logic [gdad_pkg::STAT_W-1:0]            rsp_status
);
   import gdad_pkg::*;

   gdad_cmd_type cmd;
   gdad_sts_type sts;

   gdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gdad_datapath u_datapath (
      .clock          (clock),
      .req_in_day     (req_in_day),
      .req_in_month   (req_in_month),
      .req_in_year    (req_in_year),
      .req_day_offset (req_day_offset),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_out_day    (rsp_out_day),
      .rsp_out_month  (rsp_out_month),
      .rsp_out_year   (rsp_out_year),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire
